// ===== sv/c3x3_pkg.sv =====
package c3x3_pkg;

  localparam int ROW_WIDTH   = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int KTAPS       = 3;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int Y_BITS      = 35;
  localparam int BIAS_BITS   = 32;
  localparam int KROW_BITS   = KTAPS * SAMPLE_BITS;
  localparam int CFG_BITS    = KROW_BITS;

  localparam int IN_TDATA_BITS  = ((ROW_WIDTH * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = ROW_WIDTH * Y_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REG_KERNEL_ROW0 = 3'd0,
    REG_KERNEL_ROW1 = 3'd1,
    REG_KERNEL_ROW2 = 3'd2,
    REG_BIAS_VALUE  = 3'd3,
    REG_ADD_BIAS    = 3'd4
  } reg_index_t;

  typedef logic [ROW_WIDTH-1:0][SAMPLE_BITS-1:0] row_t;
  typedef logic [KTAPS-1:0][SAMPLE_BITS-1:0]     krow_t;
  typedef logic signed [PROD_BITS-1:0]           prod_t;
  typedef logic signed [Y_BITS-1:0]              ysum_t;

  typedef struct packed {
    krow_t [KTAPS-1:0]           kernel;
    logic signed [BIAS_BITS-1:0] bias;
    logic                        add_bias;
  } cfg_t;

  // One convolution to perform: the rows above, at and below the centre.
  typedef struct packed {
    row_t up;
    row_t mid;
    row_t dn;
    logic last;
  } job_t;

endpackage

// ===== sv/c3x3_mac.sv =====
module c3x3_mac (
  input  logic                clk,
  input  logic                rst,
  input  c3x3_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  c3x3_pkg::job_t      in_job,
  output logic                out_valid,
  input  logic                out_ready,
  output c3x3_pkg::ysum_t     out_y [c3x3_pkg::ROW_WIDTH],
  output logic                out_last
);

  localparam int RW = c3x3_pkg::ROW_WIDTH;
  localparam int KT = c3x3_pkg::KTAPS;

  c3x3_pkg::prod_t prod_next [RW][KT][KT];
  c3x3_pkg::prod_t prod      [RW][KT][KT];
  logic            prod_valid;
  logic            prod_last;
  logic            prod_ready;

  c3x3_pkg::ysum_t y_next [RW];
  c3x3_pkg::ysum_t y      [RW];
  logic            y_valid;
  logic            y_last;
  logic            y_ready;

  c3x3_pkg::row_t  rows [KT];
  c3x3_pkg::ysum_t bias_ext;

  assign y_ready    = !y_valid || out_ready;
  assign prod_ready = !prod_valid || y_ready;
  assign in_ready   = prod_ready;

  assign rows[0] = in_job.up;
  assign rows[1] = in_job.mid;
  assign rows[2] = in_job.dn;

  // Taps that fall left of column 0 or right of the last column are padding.
  for (genvar c = 0; c < RW; c++) begin : g_col
    for (genvar a = 0; a < KT; a++) begin : g_krow
      for (genvar b = 0; b < KT; b++) begin : g_ktap
        localparam int COL = c + b - 1;
        if (COL >= 0 && COL < RW) begin : g_tap
          assign prod_next[c][a][b] =
              c3x3_pkg::prod_t'($signed(cfg.kernel[a][b]))
              * c3x3_pkg::prod_t'($signed(rows[a][COL]));
        end else begin : g_pad
          assign prod_next[c][a][b] = '0;
        end
      end
    end
  end

  assign bias_ext = cfg.add_bias ? c3x3_pkg::ysum_t'(cfg.bias) : '0;

  always_comb begin
    c3x3_pkg::ysum_t rsum [KT];
    for (int c = 0; c < RW; c++) begin
      for (int a = 0; a < KT; a++) begin
        rsum[a] = c3x3_pkg::ysum_t'(prod[c][a][0]) + c3x3_pkg::ysum_t'(prod[c][a][1])
                + c3x3_pkg::ysum_t'(prod[c][a][2]);
      end
      y_next[c] = (rsum[0] + rsum[1]) + (rsum[2] + bias_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      y_valid    <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (y_ready) begin
        y_valid <= prod_valid;
      end
    end
    if (prod_ready && in_valid) begin
      prod      <= prod_next;
      prod_last <= in_job.last;
    end
    if (y_ready && prod_valid) begin
      y      <= y_next;
      y_last <= prod_last;
    end
  end

  assign out_valid = y_valid;
  assign out_y     = y;
  assign out_last  = y_last;

endmodule

// ===== sv/conv3x3_same_pad_row_stream.sv =====
// Channel  Direction  Transaction carries
// s_*      in         one row: x0..x3 in tdata, last_row in tlast
// m_*      out        one output row: y0..y3 in tdata, last_out in tlast
// cfg_*    in         register write, no handshake
//
// One row is accepted per cycle while s_tready is high; a last row that follows
// earlier rows produces two output rows and holds s_tready low while the second
// convolution waits in the pending register. The output row released by an
// accepted row passes through the job, product and sum registers before it is
// valid on m_*.
// Reset is synchronous and clears the held rows and all stage valid flags.
// A stall on m_tready backs up through the stages and then drops s_tready.
module conv3x3_same_pad_row_stream (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [c3x3_pkg::IN_TDATA_BITS-1:0]     s_tdata,   // x0, x1, x2, x3
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [c3x3_pkg::OUT_TDATA_BITS-1:0]    m_tdata,   // y0, y1, y2, y3, zero fill
  output logic                                   m_tlast,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [c3x3_pkg::CFG_BITS-1:0]          cfg_data
);

  c3x3_pkg::cfg_t  cfg;
  c3x3_pkg::row_t  older_row;
  c3x3_pkg::row_t  newer_row;
  logic [1:0]      rows_held;
  c3x3_pkg::row_t  cur_row;

  c3x3_pkg::job_t  job_prev;
  c3x3_pkg::job_t  job_final;
  c3x3_pkg::job_t  s1_job;
  c3x3_pkg::job_t  pend_job;
  logic            s1_valid;
  logic            pend_valid;
  logic            s1_ready;
  logic            mac_ready;
  logic            in_acc;
  logic            has_prev;

  c3x3_pkg::ysum_t y [c3x3_pkg::ROW_WIDTH];

  assign cur_row  = s_tdata[c3x3_pkg::ROW_WIDTH*c3x3_pkg::SAMPLE_BITS-1:0];
  assign has_prev = (rows_held != 2'd0);

  assign s1_ready = !s1_valid || mac_ready;
  assign s_tready = s1_ready && !pend_valid;
  assign in_acc   = s_tvalid && s_tready;

  always_comb begin
    job_prev.up    = (rows_held == 2'd2) ? older_row : '0;
    job_prev.mid   = newer_row;
    job_prev.dn    = cur_row;
    job_prev.last  = 1'b0;
    job_final.up   = has_prev ? newer_row : '0;
    job_final.mid  = cur_row;
    job_final.dn   = '0;
    job_final.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel   <= '0;
      cfg.bias     <= '0;
      cfg.add_bias <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        c3x3_pkg::REG_KERNEL_ROW0: cfg.kernel[0] <= cfg_data[c3x3_pkg::KROW_BITS-1:0];
        c3x3_pkg::REG_KERNEL_ROW1: cfg.kernel[1] <= cfg_data[c3x3_pkg::KROW_BITS-1:0];
        c3x3_pkg::REG_KERNEL_ROW2: cfg.kernel[2] <= cfg_data[c3x3_pkg::KROW_BITS-1:0];
        c3x3_pkg::REG_BIAS_VALUE:  cfg.bias      <= cfg_data[c3x3_pkg::BIAS_BITS-1:0];
        c3x3_pkg::REG_ADD_BIAS:    cfg.add_bias  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_row  <= '0;
      newer_row  <= '0;
      rows_held  <= 2'd0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (s_tlast) begin
          older_row <= '0;
          newer_row <= '0;
          rows_held <= 2'd0;
        end else begin
          older_row <= has_prev ? newer_row : '0;
          newer_row <= cur_row;
          if (rows_held != 2'd2) begin
            rows_held <= rows_held + 2'd1;
          end
        end
      end
      // The flush row of a map waits in the pending register until stage 1 can take it.
      if (s1_ready) begin
        if (pend_valid) begin
          s1_valid   <= 1'b1;
          s1_job     <= pend_job;
          pend_valid <= 1'b0;
        end else if (in_acc) begin
          s1_valid   <= has_prev || s_tlast;
          s1_job     <= has_prev ? job_prev : job_final;
          pend_valid <= has_prev && s_tlast;
          pend_job   <= job_final;
        end else begin
          s1_valid <= 1'b0;
        end
      end
    end
  end

  c3x3_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_ready  (mac_ready),
    .in_job    (s1_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_y     (y),
    .out_last  (m_tlast)
  );

  assign m_tdata = {(c3x3_pkg::OUT_TDATA_BITS - c3x3_pkg::OUT_FIELD_BITS)'(0),
                    y[3], y[2], y[1], y[0]};

endmodule

// ===== sv/c3x3_checker.sv =====
module c3x3_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                s_tlast,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [c3x3_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic                                m_tlast
);

  logic row_seen;

  // Set while the current map has at least one accepted row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_seen <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      row_seen <= !s_tlast;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transaction changed");

  a_flush_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && row_seen |=> !s_tready)
    else $error("input taken while the flush row was still pending");

  a_no_unknown: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tready, m_tvalid}) && (!m_tvalid || !$isunknown({m_tdata, m_tlast})))
    else $error("handshake or output transaction unknown");

endmodule

bind conv3x3_same_pad_row_stream c3x3_checker u_c3x3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
